/* rtl/core/rcs_pkg.sv */
`default_nettype none
package rcs_pkg;
	localparam int WORD_BITS_DEF = 64;
	localparam int FIELD_BITS = 63;
	localparam int CFG_IDX_BITS = 2;
	localparam int CFG_DATA_BITS = 64;
	// register stages through one reduction unit
	localparam int BARRETT_STAGES = 10;
	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_MODULUS = 2'd0,
		REG_RATIO_LOW = 2'd1,
		REG_RATIO_HIGH = 2'd2
	} cfg_reg_t;
endpackage
`default_nettype wire

/* rtl/core/rcs_stream_if.sv */
`default_nettype none
interface rcs_stream_if #(parameter int PAYLOAD_BITS = 126);
	logic valid;
	logic ready;
	logic [PAYLOAD_BITS-1:0] payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* rtl/core/rcs_barrett.sv */
`default_nettype none
// One Barrett modular product through ten registered stages; enable stalls all stages.
// Every word product is split into half-word products in one stage and summed in the next.
module rcs_barrett import rcs_pkg::*; #(
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input wire logic clk,
	input wire logic en,
	input wire logic dbl,
	input wire logic [FIELD_BITS-1:0] a,
	input wire logic [FIELD_BITS-1:0] b,
	input wire logic [WORD_BITS-1:0] q,
	input wire logic [WORD_BITS-1:0] r0,
	input wire logic [WORD_BITS-1:0] r1,
	output logic [FIELD_BITS-1:0] res
);
	localparam int W = WORD_BITS;
	localparam int H = (W + 1) / 2;
	localparam int P = 2 * H;
	localparam int F = 4 * H;

	// half products in the order low*low, low*high, high*low, high*high
	typedef logic [3:0][P-1:0] quad_t;

	function automatic logic [P-1:0] half_mul(input logic [H-1:0] x, input logic [H-1:0] y);
		logic [P-1:0] xe, ye;
		xe = P'(x);
		ye = P'(y);
		return xe * ye;
	endfunction

	function automatic quad_t half_products(input logic [P-1:0] x, input logic [P-1:0] y);
		quad_t pp;
		pp[0] = half_mul(x[H-1:0], y[H-1:0]);
		pp[1] = half_mul(x[H-1:0], y[P-1:H]);
		pp[2] = half_mul(x[P-1:H], y[H-1:0]);
		pp[3] = half_mul(x[P-1:H], y[P-1:H]);
		return pp;
	endfunction

	function automatic logic [F-1:0] pp_sum(input quad_t pp);
		logic [F-1:0] mid;
		mid = F'(pp[1]) + F'(pp[2]);
		return {pp[3], pp[0]} + (mid << H);
	endfunction

	logic [P-1:0] aw, bw, qe, r0e, r1e, z0e, z1e, este;
	quad_t z_s1, p00_s3, p01_s3, p10_s3, p11_s3, eq_s7;
	logic [F-1:0] zsum, p00sum, p01sum, p10sum, p11sum, eqsum;
	logic [W-1:0] z0_s2, z1_s2;
	logic [W-1:0] z0_s3, z0_s4, z0_s5, z0_s6, z0_s7, z0_s8;
	logic [2*W-1:0] p00_s4, p01_s4, p10_s4;
	logic [W-1:0] p11_s4;
	logic [W:0] s1w, s2w;
	logic [W-1:0] t3w, cyw;
	logic [W-1:0] t3_s5, cy_s5, p11_s5, est_s6, eq_s8, red_s9;
	logic [W-1:0] rem, red, dsum, dred;
	logic [FIELD_BITS-1:0] res_s10;

	assign aw = P'(W'(a));
	assign bw = P'(W'(b));
	assign qe = P'(q);
	assign r0e = P'(r0);
	assign r1e = P'(r1);
	assign z0e = P'(z0_s2);
	assign z1e = P'(z1_s2);
	assign este = P'(est_s6);

	assign zsum = pp_sum(z_s1);
	assign p00sum = pp_sum(p00_s3);
	assign p01sum = pp_sum(p01_s3);
	assign p10sum = pp_sum(p10_s3);
	assign p11sum = pp_sum(p11_s3);
	assign eqsum = pp_sum(eq_s7);

	assign s1w = {1'b0, p01_s4[W-1:0]} + {1'b0, p00_s4[2*W-1:W]};
	assign t3w = p01_s4[2*W-1:W] + W'(s1w[W]);
	assign s2w = {1'b0, s1w[W-1:0]} + {1'b0, p10_s4[W-1:0]};
	assign cyw = p10_s4[2*W-1:W] + W'(s2w[W]);

	assign rem = z0_s8 - eq_s8;
	assign red = (rem >= q) ? rem - q : rem;
	assign dsum = red_s9 + red_s9;
	assign dred = (dsum >= q) ? dsum - q : dsum;

	always_ff @(posedge clk) begin
		if (en) begin
			z_s1 <= half_products(aw, bw);
			z0_s2 <= zsum[W-1:0];
			z1_s2 <= zsum[2*W-1:W];
			p00_s3 <= half_products(z0e, r0e);
			p01_s3 <= half_products(z0e, r1e);
			p10_s3 <= half_products(z1e, r0e);
			p11_s3 <= half_products(z1e, r1e);
			z0_s3 <= z0_s2;
			p00_s4 <= p00sum[2*W-1:0];
			p01_s4 <= p01sum[2*W-1:0];
			p10_s4 <= p10sum[2*W-1:0];
			p11_s4 <= p11sum[W-1:0];
			z0_s4 <= z0_s3;
			t3_s5 <= t3w;
			cy_s5 <= cyw;
			p11_s5 <= p11_s4;
			z0_s5 <= z0_s4;
			est_s6 <= p11_s5 + t3_s5 + cy_s5;
			z0_s6 <= z0_s5;
			eq_s7 <= half_products(este, qe);
			z0_s7 <= z0_s6;
			eq_s8 <= eqsum[W-1:0];
			z0_s8 <= z0_s7;
			red_s9 <= red;
			res_s10 <= FIELD_BITS'(dbl ? dred : red_s9);
		end
	end
	assign res = res_s10;
endmodule
`default_nettype wire

/* rtl/core/rns_ciphertext_square.sv */
`default_nettype none
// Squares one ciphertext coefficient pair (coeff_zero, coeff_one) modulo the
// configured channel modulus by Barrett reduction. One pair is taken every
// cycle unless stalled; a result is offered once its input transfer has
// passed the ten register stages of each reduction unit (every word product
// is split into half-word products and summed in the following stage).
// Three reduction units run side by side; a held-off output stalls the whole
// pipeline, and the input with it, only when the last stage holds a result.
// Write configuration only while the pipeline is empty.
module rns_ciphertext_square import rcs_pkg::*; #(
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [CFG_IDX_BITS-1:0] cfg_idx,
	input wire logic [CFG_DATA_BITS-1:0] cfg_data,
	rcs_stream_if.sink in_ch,
	rcs_stream_if.source out_ch
);
	localparam int DEPTH = BARRETT_STAGES;
	logic [FIELD_BITS-1:0] modulus_q;
	logic [CFG_DATA_BITS-1:0] ratio_low_q, ratio_high_q;
	logic [WORD_BITS-1:0] qw, r0w, r1w;
	logic [DEPTH-1:0] vld_q;
	logic en;
	logic [FIELD_BITS-1:0] c0, c1, sq0, sq1, cr;

	assign qw = WORD_BITS'(modulus_q);
	assign r0w = ratio_low_q[WORD_BITS-1:0];
	assign r1w = ratio_high_q[WORD_BITS-1:0];
	assign en = !vld_q[DEPTH-1] || out_ch.ready;
	assign in_ch.ready = en;
	assign c0 = in_ch.payload[FIELD_BITS-1:0];
	assign c1 = in_ch.payload[2*FIELD_BITS-1:FIELD_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= FIELD_BITS'(2);
			ratio_low_q <= '0;
			ratio_high_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_MODULUS: modulus_q <= cfg_data[FIELD_BITS-1:0];
				REG_RATIO_LOW: ratio_low_q <= cfg_data;
				REG_RATIO_HIGH: ratio_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// advance valid bits with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[DEPTH-2:0], in_ch.valid};
		end
	end

	rcs_barrett #(.WORD_BITS(WORD_BITS)) u_sq0 (.clk(clk), .en(en), .dbl(1'b0),
		.a(c0), .b(c0), .q(qw), .r0(r0w), .r1(r1w), .res(sq0));
	rcs_barrett #(.WORD_BITS(WORD_BITS)) u_sq1 (.clk(clk), .en(en), .dbl(1'b0),
		.a(c1), .b(c1), .q(qw), .r0(r0w), .r1(r1w), .res(sq1));
	rcs_barrett #(.WORD_BITS(WORD_BITS)) u_cross (.clk(clk), .en(en), .dbl(1'b1),
		.a(c0), .b(c1), .q(qw), .r0(r0w), .r1(r1w), .res(cr));

	assign out_ch.valid = vld_q[DEPTH-1];
	assign out_ch.payload = {cr, sq1, sq0};
endmodule
`default_nettype wire

/* sim/rcs_square_checker.sv */
`timescale 1ns / 1ps
module rcs_square_checker import rcs_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_idx,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	rcs_stream_if                    in_mon,
	rcs_stream_if                    out_mon,
	output int                       errors,
	output int                       pending,
	output int                       squares_seen
);

	typedef struct packed {
		logic [FIELD_BITS-1:0] cross_term;
		logic [FIELD_BITS-1:0] square_one;
		logic [FIELD_BITS-1:0] square_zero;
	} square_set_t;

	logic [63:0] modulus_q;
	logic [63:0] ratio_lo;
	logic [63:0] ratio_hi;
	square_set_t squares_due[$];

	function automatic logic [127:0] wide_mul(logic [63:0] a, logic [63:0] b);
		return {64'd0, a} * {64'd0, b};
	endfunction

	// Barrett reduction with a truncated two-word quotient estimate
	function automatic logic [63:0] barrett_mul(logic [63:0] a, logic [63:0] b);
		logic [127:0] z, p;
		logic [64:0]  s1, s2;
		logic [63:0]  c, t3, cy, est, rem;
		z   = wide_mul(a, b);
		p   = wide_mul(z[63:0], ratio_lo);
		c   = p[127:64];
		p   = wide_mul(z[63:0], ratio_hi);
		s1  = {1'b0, p[63:0]} + {1'b0, c};
		t3  = p[127:64] + {63'd0, s1[64]};
		p   = wide_mul(z[127:64], ratio_lo);
		s2  = {1'b0, s1[63:0]} + {1'b0, p[63:0]};
		cy  = p[127:64] + {63'd0, s2[64]};
		est = z[127:64] * ratio_hi + t3 + cy;
		rem = z[63:0] - est * modulus_q;
		if (rem >= modulus_q)
			rem = rem - modulus_q;
		return rem;
	endfunction

	function automatic square_set_t predict_squares(logic [FIELD_BITS-1:0] c0,
			logic [FIELD_BITS-1:0] c1);
		square_set_t r;
		logic [63:0] x, s;
		r.square_zero = FIELD_BITS'(barrett_mul({1'b0, c0}, {1'b0, c0}));
		r.square_one  = FIELD_BITS'(barrett_mul({1'b0, c1}, {1'b0, c1}));
		x = barrett_mul({1'b0, c0}, {1'b0, c1});
		s = x + x;
		if (s >= modulus_q)
			s = s - modulus_q;
		r.cross_term = s[FIELD_BITS-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		square_set_t exp_r, got;
		if (!arst_n) begin
			modulus_q    <= 64'd2;
			ratio_lo     <= '0;
			ratio_hi     <= '0;
			errors       <= 0;
			pending      <= 0;
			squares_seen <= 0;
			squares_due.delete();
		end else begin
			if (in_mon.valid && in_mon.ready)
				squares_due.push_back(predict_squares(in_mon.payload[62:0],
					in_mon.payload[125:63]));
			if (out_mon.valid && out_mon.ready) begin
				got = out_mon.payload;
				squares_seen <= squares_seen + 1;
				if (squares_due.size() == 0) begin
					$error("result transfer with nothing expected: %h", got);
					errors <= errors + 1;
				end else begin
					exp_r = squares_due.pop_front();
					if (got.square_zero !== exp_r.square_zero) begin
						$error("square_zero expected %h actual %h",
							exp_r.square_zero, got.square_zero);
						errors <= errors + 1;
					end
					if (got.square_one !== exp_r.square_one) begin
						$error("square_one expected %h actual %h",
							exp_r.square_one, got.square_one);
						errors <= errors + 1;
					end
					if (got.cross_term !== exp_r.cross_term) begin
						$error("cross_term expected %h actual %h",
							exp_r.cross_term, got.cross_term);
						errors <= errors + 1;
					end
				end
			end
			pending <= squares_due.size();
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_idx))
					REG_MODULUS: begin
						modulus_q <= {1'b0, cfg_data[62:0]};
					end
					REG_RATIO_LOW: begin
						ratio_lo <= cfg_data;
					end
					REG_RATIO_HIGH: begin
						ratio_hi <= cfg_data;
					end
					default: begin
					end
				endcase
			end
		end
	end

endmodule

/* sim/rns_ciphertext_square_tb.sv */
`timescale 1ns / 1ps
module rns_ciphertext_square_tb;
	import rcs_pkg::*;

	localparam int  PHASES      = 8;
	localparam int  RAND_ITEMS  = 150;
	localparam longint MAX_CYCLES = 3000000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_BITS-1:0]  cfg_idx;
	logic [CFG_DATA_BITS-1:0] cfg_data;
	int errors, pending, squares_seen;
	longint cycles = 0;
	int items_sent;
	bit long_hold_req = 1'b0;

	rcs_stream_if #(.PAYLOAD_BITS(126)) in_ch ();
	rcs_stream_if #(.PAYLOAD_BITS(189)) out_ch ();

	rns_ciphertext_square u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch)
	);

	rcs_square_checker u_checker (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data), .in_mon(in_ch), .out_mon(out_ch),
		.errors(errors), .pending(pending), .squares_seen(squares_seen)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > MAX_CYCLES) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [62:0] rand63();
		logic [63:0] v;
		v = {$urandom, $urandom};
		return v[62:0];
	endfunction

	function automatic logic [127:0] barrett_ratio(logic [62:0] q);
		logic [128:0] num;
		num = 129'd1 << 128;
		return 128'(num / {66'd0, q});
	endfunction

	// Receiver: random runs of readiness, with one long hold-off on request
	initial begin
		int n;
		bit held;
		held = 1'b0;
		out_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (long_hold_req && !held) begin
				out_ch.ready <= 1'b0;
				repeat (400) @(posedge clk);
				held = 1'b1;
			end
			n = $urandom_range(1, 30);
			out_ch.ready <= 1'b1;
			repeat (n) @(posedge clk);
			n = gap_len();
			if (n > 0) begin
				out_ch.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
		end
	end

	task automatic send_pair(logic [62:0] c0, logic [62:0] c1);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_ch.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_ch.valid   <= 1'b1;
		in_ch.payload <= {c1, c0};
		do @(negedge clk); while (!in_ch.ready);
		@(posedge clk);
		items_sent++;
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [63:0] data);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we   <= 1'b0;
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic setup_channel(int phase, output logic [62:0] q);
		logic [127:0] ratio;
		case (phase)
			1: q = 63'h7FFF_FFFF_FFFF_FFFF;
			2: q = 63'd3;
			3: q = rand63() | 63'h4000_0000_0000_0001;
			4: q = (rand63() >> 23) | 63'd1;
			5: q = 63'd0;
			6: q = 63'd1;
			default: q = rand63();
		endcase
		ratio = barrett_ratio(q == 0 ? 63'd1 : q);
		if (phase == 5 || phase == 7)
			ratio = {$urandom, $urandom, $urandom, $urandom};
		write_reg(REG_MODULUS, {$urandom_range(0, 1) == 1, q});
		write_reg(REG_RATIO_LOW, ratio[63:0]);
		write_reg(REG_RATIO_HIGH, ratio[127:64]);
	endtask

	task automatic directed_pairs(logic [62:0] q);
		logic [62:0] top, qm;
		top = '1;
		qm  = (q == 0) ? top : q - 1;
		send_pair('0, '0);
		send_pair(top, top);
		send_pair('0, top);
		send_pair(top, '0);
		send_pair(qm, qm);
		send_pair(63'd1, qm);
		send_pair(qm, 63'd1);
		send_pair(63'd1, 63'd1);
		send_pair(63'h4000_0000_0000_0000, 63'h4000_0000_0000_0000);
		send_pair(63'h5555_5555_5555_5555, 63'h2AAA_AAAA_AAAA_AAAA);
		send_pair(q >> 1, qm);
		send_pair(qm >> 1, (qm >> 1) + 63'd1);
	endtask

	initial begin
		logic [62:0] q;
		logic [62:0] a, b;
		arst_n        = 1'b0;
		items_sent    = 0;
		cfg_we        <= 1'b0;
		cfg_idx       <= REG_MODULUS;
		cfg_data      <= '0;
		in_ch.valid   <= 1'b0;
		in_ch.payload <= '0;
		repeat (9) @(posedge clk);
		arst_n = 1'b1;
		@(posedge clk);
		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph == 0)
				q = 63'd2;
			else
				setup_channel(ph, q);
			if (ph < 2)
				directed_pairs(q);
			if (ph == 2)
				long_hold_req = 1'b1;
			for (int i = 0; i < RAND_ITEMS; i++) begin
				if (q != 0 && $urandom_range(0, 99) < 85) begin
					a = rand63() % q;
					b = rand63() % q;
				end else begin
					a = rand63();
					b = rand63();
				end
				send_pair(a, b);
			end
			drain();
		end
		repeat (20) @(posedge clk);
		$display("Sent %0d coefficient pairs over %0d modulus settings, %0d results checked",
			items_sent, PHASES, squares_seen);
		$display("Covered reset constants, zero and unit moduli, mismatched ratios, long stall");
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
